@@ design/pat_section_lcn_extractor_defines.svh @@
// Assertion macros shared by the design files.
`ifndef PAT_SECTION_LCN_EXTRACTOR_DEFINES_SVH
`define PAT_SECTION_LCN_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PSLE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psle check failed");
`define PSLE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("psle forbidden condition");
`else
`define PSLE_ASSERT(label, prop)
`define PSLE_ASSERT_NEVER(label, cond)
`endif

`endif

@@ design/psle_pkg.sv @@
package psle_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_ENTRY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PROG = 2'd0,
    KIND_DONE = 2'd1,
    KIND_IGN  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       section_start;
  } in_item_t;

  typedef struct packed {
    kind_t        result_kind;
    logic [15:0]  service_id;
    logic [15:0]  stream_id;
    logic [31:0]  channel_number;
    logic         last;
  } out_item_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_KHZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ID = 1'b1;

  // section header layout
  localparam logic [10:0] POS_LEN_HI   = 11'd1;
  localparam logic [10:0] POS_LEN_LO   = 11'd2;
  localparam logic [10:0] POS_TS_HI    = 11'd3;
  localparam logic [10:0] POS_TS_LO    = 11'd4;
  localparam logic [10:0] POS_HDR_LAST = 11'd7;
  localparam logic [10:0] POS_MAX      = 11'h7FF;
  localparam logic [1:0]  ENTRY_LAST_OFF = 2'd3;
  localparam logic [11:0] LEN_MAX      = 12'd1022;
  localparam logic [11:0] LOOP_OFFSET  = 12'd9;
  localparam logic [11:0] ENTRY_BYTES  = 12'd4;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

endpackage

@@ design/pat_section_lcn_extractor.sv @@
// PAT section parser: takes one section byte per request and emits one
// result per nonzero program entry (service id, stream id, channel number =
// frequency_khz<<16 | entry index), then a done result; a bad table id or
// a section length over 1022 gives one ignored result instead. A byte can be
// accepted every cycle while in_ready is high, and its results are registered
// into a four-entry output queue; in_ready drops while fewer than two slots
// are free, so the rate is one byte per cycle as long as the consumer takes
// one result per cycle. The last byte of a section that ends on a program
// entry gives two results, written to the queue together.
`include "pat_section_lcn_extractor_defines.svh"

module pat_section_lcn_extractor
  import psle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] freq_khz_r;
  logic [7:0]  table_id_r;

  phase_t      phase_r, phase_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [11:0] len_r, len_nxt;
  logic [15:0] stream_r, stream_nxt;
  logic [23:0] entry_r, entry_nxt;
  logic [11:0] left_r, left_nxt;
  logic [8:0]  index_r, index_nxt;

  logic        in_fire;
  logic        emit_ign, emit_prog, emit_done;
  logic [15:0] prog_sid;
  logic [11:0] len_v;
  logic [1:0]  res_n;
  out_item_t   res0, res1;

  out_item_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pop;

  assign in_ready  = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_khz_r <= '0;
      table_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_KHZ: freq_khz_r <= cfg_wdata;
        REG_TABLE_ID: table_id_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // parse state, next value
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    stream_nxt = stream_r;
    entry_nxt  = entry_r;
    left_nxt   = left_r;
    index_nxt  = index_r;
    emit_ign   = 1'b0;
    emit_prog  = 1'b0;
    emit_done  = 1'b0;
    prog_sid   = entry_r[23:8];
    len_v      = {len_r[11:8], in_data.section_byte};
    if (in_fire) begin
      if (in_data.section_start) begin
        pos_nxt    = '0;
        len_nxt    = '0;
        stream_nxt = '0;
        entry_nxt  = '0;
        left_nxt   = '0;
        index_nxt  = '0;
        if (in_data.section_byte != table_id_r) begin
          phase_nxt = PH_IDLE;
          emit_ign  = 1'b1;
        end else begin
          phase_nxt = PH_HEAD;
          pos_nxt   = 11'd1;
        end
      end else begin
        case (phase_r)
          PH_HEAD: begin
            case (pos_r)
              POS_LEN_HI: len_nxt = {in_data.section_byte[3:0], 8'h00};
              POS_LEN_LO: begin
                len_nxt = len_v;
                if (len_v > LEN_MAX) begin
                  phase_nxt = PH_IDLE;
                  emit_ign  = 1'b1;
                end else begin
                  left_nxt = (len_v > LOOP_OFFSET) ? (len_v - LOOP_OFFSET) : '0;
                end
              end
              POS_TS_HI: stream_nxt = {in_data.section_byte, 8'h00};
              POS_TS_LO: stream_nxt = {stream_r[15:8], in_data.section_byte};
              POS_HDR_LAST: begin
                if (left_r == '0) begin
                  phase_nxt = PH_IDLE;
                  emit_done = 1'b1;
                end else begin
                  phase_nxt = PH_ENTRY;
                end
              end
              default: ;
            endcase
            pos_nxt = pos_r + 11'd1;
          end
          PH_ENTRY: begin
            // entries start at byte 8, so the low two bits give the offset
            if (pos_r[1:0] != ENTRY_LAST_OFF) begin
              entry_nxt = {entry_r[15:0], in_data.section_byte};
            end else begin
              if (prog_sid != '0) begin
                emit_prog = 1'b1;
                index_nxt = index_r + 9'd1;
              end
              entry_nxt = '0;
              if (left_r <= ENTRY_BYTES) begin
                left_nxt  = '0;
                phase_nxt = PH_IDLE;
                emit_done = 1'b1;
              end else begin
                left_nxt = left_r - ENTRY_BYTES;
              end
            end
            if (pos_r != POS_MAX) pos_nxt = pos_r + 11'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // results for this byte: program first, then done
  always_comb begin
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (emit_prog) begin
      res0.result_kind    = KIND_PROG;
      res0.service_id     = prog_sid;
      res0.stream_id      = stream_r;
      res0.channel_number = {freq_khz_r, 7'd0, index_r};
      res0.last           = !emit_done;
      res1.result_kind    = KIND_DONE;
      res1.stream_id      = stream_r;
      res1.last           = 1'b1;
      res_n               = emit_done ? 2'd2 : 2'd1;
    end else if (emit_done) begin
      res0.result_kind = KIND_DONE;
      res0.stream_id   = stream_r;
      res0.last        = 1'b1;
      res_n            = 2'd1;
    end else if (emit_ign) begin
      res0.result_kind = KIND_IGN;
      res0.last        = 1'b1;
      res_n            = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      len_r    <= '0;
      stream_r <= '0;
      entry_r  <= '0;
      left_r   <= '0;
      index_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      stream_r <= stream_nxt;
      entry_r  <= entry_nxt;
      left_r   <= left_nxt;
      index_r  <= index_nxt;
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(res_n);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_r + CNT_W'(res_n) - CNT_W'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_n != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (res_n == 2'd2) fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res1;
  end

  `PSLE_ASSERT_NEVER(a_queue_overflow, cnt_r > CNT_W'(FIFO_DEPTH))
  `PSLE_ASSERT(a_entry_has_bytes, (phase_r == PH_ENTRY) |-> (left_r != '0))
  `PSLE_ASSERT(a_entry_clear_outside, (phase_r != PH_ENTRY) |-> (entry_r == '0))
  `PSLE_ASSERT(a_two_results_end, (res_n == 2'd2) |=> (phase_r == PH_IDLE))

endmodule

@@ sim/pat_section_lcn_extractor_check.sv @@
module pat_section_lcn_extractor_check
  import psle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    n_prog,
  output int                    n_done,
  output int                    n_ign
);

  // register copies
  logic [15:0] freq_khz;
  logic [7:0]  table_id;

  // parser state
  phase_t      phase;
  logic [10:0] pos;
  logic [11:0] sec_len;
  logic [15:0] ts_id;
  logic [23:0] ent;
  logic [11:0] left;
  logic [8:0]  prog_idx;

  out_item_t   expected_results[$];
  int          errs;
  int          progs, dones, igns;

  initial begin
    errs  = 0;
    progs = 0;
    dones = 0;
    igns  = 0;
  end

  task automatic emit(input kind_t k, input logic [15:0] svc, input logic [15:0] ts,
                      input logic [31:0] chan, input logic fin);
    out_item_t r;
    r.result_kind    = k;
    r.service_id     = svc;
    r.stream_id      = ts;
    r.channel_number = chan;
    r.last           = fin;
    expected_results.push_back(r);
  endtask

  task automatic parse_byte(input in_item_t it);
    logic [7:0]  b;
    logic [10:0] p;
    logic [15:0] svc;
    logic        fin;
    b = it.section_byte;
    if (it.section_start) begin
      pos      = '0;
      sec_len  = '0;
      ts_id    = '0;
      ent      = '0;
      left     = '0;
      prog_idx = '0;
      if (b != table_id) begin
        phase = PH_IDLE;
        emit(KIND_IGN, 16'h0, 16'h0, 32'h0, 1'b1);
      end else begin
        phase = PH_HEAD;
        pos   = POS_LEN_HI;
      end
    end else if (phase == PH_HEAD) begin
      p = pos;
      if (p == POS_LEN_HI) begin
        sec_len = {b[3:0], 8'h00};
      end else if (p == POS_LEN_LO) begin
        sec_len = sec_len | {4'h0, b};
        if (sec_len > LEN_MAX) begin
          phase = PH_IDLE;
          emit(KIND_IGN, 16'h0, 16'h0, 32'h0, 1'b1);
        end else begin
          left = (sec_len > LOOP_OFFSET) ? sec_len - LOOP_OFFSET : 12'h0;
        end
      end else if (p == POS_TS_HI) begin
        ts_id = {b, 8'h00};
      end else if (p == POS_TS_LO) begin
        ts_id = ts_id | {8'h00, b};
      end else if (p == POS_HDR_LAST) begin
        if (left == 12'h0) begin
          phase = PH_IDLE;
          emit(KIND_DONE, 16'h0, ts_id, 32'h0, 1'b1);
        end else begin
          phase = PH_ENTRY;
        end
      end
      pos = p + 11'd1;
    end else if (phase == PH_ENTRY) begin
      // entries start at offset 8, so the low two bits give the place in the entry
      if (pos[1:0] != ENTRY_LAST_OFF) begin
        ent = {ent[15:0], b};
      end else begin
        svc = ent[23:8];
        fin = (left <= ENTRY_BYTES);
        if (svc != 16'h0) begin
          emit(KIND_PROG, svc, ts_id, {freq_khz, 7'h0, prog_idx}, !fin);
          prog_idx = prog_idx + 9'd1;
        end
        ent = '0;
        if (fin) begin
          left  = '0;
          phase = PH_IDLE;
          emit(KIND_DONE, 16'h0, ts_id, 32'h0, 1'b1);
        end else begin
          left = left - ENTRY_BYTES;
        end
      end
      if (pos < POS_MAX) pos = pos + 11'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      freq_khz = '0;
      table_id = '0;
      phase    = PH_IDLE;
      pos      = '0;
      sec_len  = '0;
      ts_id    = '0;
      ent      = '0;
      left     = '0;
      prog_idx = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FREQ_KHZ) freq_khz = cfg_wdata;
        else if (cfg_index == REG_TABLE_ID) table_id = cfg_wdata[7:0];
      end
      if (in_valid && in_ready) parse_byte(in_data);
      if (out_valid && out_ready) begin
        if (out_data.result_kind == KIND_PROG) progs++;
        else if (out_data.result_kind == KIND_DONE) dones++;
        else igns++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d service %0h", out_data.result_kind,
                 out_data.service_id);
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
          check_field("service_id", 32'(want.service_id), 32'(out_data.service_id));
          check_field("stream_id", 32'(want.stream_id), 32'(out_data.stream_id));
          check_field("channel_number", want.channel_number, out_data.channel_number);
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
    fail_count <= errs;
    pending    <= expected_results.size();
    n_prog     <= progs;
    n_done     <= dones;
    n_ign      <= igns;
  end

endmodule

@@ sim/pat_section_lcn_extractor_tb.sv @@
module pat_section_lcn_extractor_tb;
  import psle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count, pending, n_prog, n_done, n_ign;

  int          burst_left;
  int          bytes_sent;
  int          parsed_bytes;
  logic [7:0]  tid_now;
  logic        hold_off_req;
  logic        hold_off_done;
  int          cycles;

  pat_section_lcn_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pat_section_lcn_extractor_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_prog     (n_prog),
    .n_done     (n_done),
    .n_ign      (n_ign)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pat_section_lcn_extractor_tb NOT OK");
    $finish;
  end

  // consumer: ready pattern changes mode at random intervals; one long
  // hold-off when asked so the result queue backs up into the byte input
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    hold_off_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        if (hold_off_req && !hold_off_done) begin
          hold_off_done = 1'b1;
          out_ready <= 1'b0;
          repeat (150) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // one request per call; bursts of back-to-back bytes with random gaps
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data.section_byte  <= b;
    in_data.section_start <= s;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] freq, input logic [7:0] tid);
    write_reg(REG_FREQ_KHZ, freq);
    write_reg(REG_TABLE_ID, {8'h00, tid});
    tid_now = tid;
  endtask

  // full or cut-short section; cut = 0 sends header, length bytes and CRC
  task automatic send_section(input logic [7:0] tid, input int len, input int cut);
    int         total;
    int         parsed;
    int         i;
    logic [7:0] b;
    logic       zero_prog;
    logic [11:0] len_f;
    len_f = len[11:0];
    total = 3 + len;
    if (cut > 0 && cut < total) total = cut;
    if (tid != tid_now) parsed = 1;
    else if (len > LEN_MAX) parsed = 3;
    else if (len > LOOP_OFFSET) parsed = 8 + 4 * ((len - LOOP_OFFSET + 3) / 4);
    else parsed = 8;
    zero_prog = 1'b0;
    for (i = 0; i < total; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        b = tid;
      end else if (i == 1) begin
        b[3:0] = len_f[11:8];
      end else if (i == 2) begin
        b = len_f[7:0];
      end else if (i >= 8 && i % 4 == 0) begin
        // network PID entries carry program number zero
        zero_prog = ($urandom_range(0, 5) == 0);
        if (zero_prog) b = 8'h00;
      end else if (i >= 8 && i % 4 == 1 && zero_prog) begin
        b = 8'h00;
      end
      send_byte(b, i == 0);
    end
    parsed_bytes += (parsed < total) ? parsed : total;
  endtask

  task automatic random_traffic;
    int pick;
    int len;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      send_section(tid_now, 9 + 4 * $urandom_range(0, 8), 0);
    end else if (pick < 76) begin
      send_section(tid_now, $urandom_range(0, 40), 0);
    end else if (pick < 83) begin
      len = 9 + 4 * $urandom_range(0, 8);
      send_section(tid_now, len, $urandom_range(1, len + 2));
    end else if (pick < 88) begin
      send_section(tid_now ^ 8'($urandom_range(1, 255)), $urandom_range(0, 40),
                   $urandom_range(1, 5));
    end else if (pick < 93) begin
      send_section(tid_now, $urandom_range(LEN_MAX + 1, 4095), 3 + $urandom_range(0, 4));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int ph;
    int target;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    burst_left    = 0;
    bytes_sent    = 0;
    parsed_bytes  = 0;
    tid_now       = 8'h00;
    hold_off_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(16'hFFFF, 8'h00);
    // wrong table id, then a stray byte while idle
    send_byte(8'h42, 1'b1);
    send_byte(8'h5A, 1'b0);
    // length 1023 with junk in the upper nibble
    send_byte(8'h00, 1'b1); send_byte(8'hF3, 1'b0); send_byte(8'hFF, 1'b0);
    // length 9: no entries, done on the last header byte
    send_byte(8'h00, 1'b1); send_byte(8'hB0, 1'b0); send_byte(8'h09, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hC1, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    // section cut off by a new start, then a network PID entry and a program
    // entry whose last byte also ends the section
    send_byte(8'h00, 1'b1); send_byte(8'hB0, 1'b0);
    send_byte(8'h00, 1'b1); send_byte(8'h70, 1'b0); send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hC1, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hE0, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hE1, 1'b0);
    send_byte(8'h00, 1'b0);
    parsed_bytes += 31;

    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_regs(16'h0000, 8'h00);
        1: set_regs(16'($urandom), 8'hFF);
        2: set_regs(16'hFFFF, 8'($urandom));
        default: set_regs(16'($urandom), 8'h00);
      endcase
      if (ph == 1) hold_off_req = 1'b1;
      target = parsed_bytes + 95;
      while (parsed_bytes < target) random_traffic();
    end

    // longest legal length, cut after its first entries
    drain();
    set_regs(16'($urandom), 8'h00);
    send_section(tid_now, LEN_MAX, 40);

    drain();
    repeat (10) @(posedge clk);
    $display("%0d bytes sent, %0d parsed, over six register settings", bytes_sent,
             parsed_bytes);
    $display("results seen: %0d program, %0d done, %0d ignored", n_prog, n_done, n_ign);
    if (fail_count == 0 && pending == 0) begin
      $display("pat_section_lcn_extractor_tb OK");
    end else begin
      $display("pat_section_lcn_extractor_tb NOT OK");
    end
    $finish;
  end

endmodule
